### design/date_add_days_defines.svh
// Assertion helpers for the date adder; clocked on i_clk, muted while i_rst_n is low.
`ifndef DATE_ADD_DAYS_DEFINES_SVH
`define DATE_ADD_DAYS_DEFINES_SVH

// Plain invariant.
`define DAD_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define DAD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

### design/dad_pkg.sv
package dad_pkg;

    localparam int unsigned DAY_W  = 5;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned YEAR_W = 12;
    localparam int unsigned OFF_W  = 18;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned DNUM_W = 20;   // March-based day number
    localparam int unsigned REST_W = 10;   // day within March-based year
    localparam int unsigned NSTG   = 10;   // pipeline depth incl. output register

    localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd1950;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2049;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_IN = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic              ok;
        logic [DNUM_W-1:0] days;   // day number + 16, before the offset
    } t_chk;

    // days from 1 March to the first of month mm (0 = March .. 11 = February)
    function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] mm);
        logic [8:0] v;
        case (mm)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // March-based month of a day within the year: count of month starts passed
    function automatic logic [MON_W-1:0] month_index(input logic [REST_W-1:0] rest);
        logic [MON_W-1:0] cnt;
        cnt = '0;
        for (int k = 1; k < 12; k++) begin
            if (rest >= {1'b0, days_before_month(MON_W'(k))}) begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

### design/date_add_days.sv
// Channel  | Handshake                  | Beat payload
// ---------+----------------------------+-------------------------------------------------
// input    | i_in_valid / o_in_ready    | i_in_day, i_in_month, i_in_year, i_day_offset
// output   | o_out_valid / i_out_ready  | o_out_day, o_out_month, o_out_year, o_status
//
// Ten register stages, output register included: one beat per cycle is taken
// while the output side keeps up.
// Each stage holds its beat until the next one has room, so a stall fills bubbles
// first and only stops the input once every stage holds a beat.
// Reset (synchronous) clears the stage valid bits; the data registers are not reset.
`include "date_add_days_defines.svh"

module date_add_days
    import dad_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [DAY_W-1:0]         i_in_day,
    input  logic [MON_W-1:0]         i_in_month,
    input  logic [YEAR_W-1:0]        i_in_year,
    input  logic signed [OFF_W-1:0]  i_day_offset,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [DAY_W-1:0]         o_out_day,
    output logic [MON_W-1:0]         o_out_month,
    output logic [YEAR_W-1:0]        o_out_year,
    output logic [STAT_W-1:0]        o_status
);

    // floor(2^32 * 10000 / 3652425): year estimate by reciprocal
    localparam logic [23:0] YR_RECIP  = 24'd11759221;
    localparam logic [33:0] YR_DIV    = 34'd3652425;
    // floor(x / 100) = (x * 1311) >> 17 for 12-bit x
    localparam logic [10:0] C_RECIP   = 11'd1311;

    // ---------------- stage control ----------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;     // stage k may load this cycle

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NSTG-1];

    // ---------------- stage 0: check date, partial day number ----------------
    t_chk chk;

    dad_date_check u_check (
        .i_day   (i_in_day),
        .i_month (i_in_month),
        .i_year  (i_in_year),
        .o_chk   (chk)
    );

    t_chk                    r_s0_chk;
    logic signed [OFF_W-1:0] r_s0_off;

    // ---------------- stage 1: add offset ----------------
    logic              r_s1_ok;
    logic [DNUM_W-1:0] r_s1_n;
    logic [20:0]       n_s1_n;

    assign n_s1_n = 21'({1'b0, r_s0_chk.days}) - 21'd16 + 21'(r_s0_off);

    // ---------------- stage 2: year estimate (may be one low) ----------------
    logic              r_s2_ok;
    logic [DNUM_W-1:0] r_s2_n;
    logic [YEAR_W-1:0] r_s2_q0;
    logic [43:0]       n_s2_prod;

    assign n_s2_prod = 44'(r_s1_n) * 44'(YR_RECIP);

    // ---------------- stage 3: scaled day number and estimate ----------------
    logic              r_s3_ok;
    logic [DNUM_W-1:0] r_s3_n;
    logic [YEAR_W-1:0] r_s3_q0;
    logic [33:0]       r_s3_x;
    logic [33:0]       r_s3_t;

    // ---------------- stage 4: fix estimate to floor((10000n+14780)/3652425) ----------------
    logic              r_s4_ok;
    logic [DNUM_W-1:0] r_s4_n;
    logic [YEAR_W-1:0] r_s4_yr;
    logic [33:0]       n_s4_rem;

    assign n_s4_rem = r_s3_x - r_s3_t;

    // ---------------- stage 5: century count ----------------
    logic              r_s5_ok;
    logic [DNUM_W-1:0] r_s5_n;
    logic [YEAR_W-1:0] r_s5_yr;
    logic [5:0]        r_s5_q100;
    logic [22:0]       n_s5_prod;

    assign n_s5_prod = 23'(r_s4_yr) * 23'(C_RECIP);

    // ---------------- stage 6: day within year, previous year's length ----------------
    logic               r_s6_ok;
    logic [YEAR_W-1:0]  r_s6_yr;
    logic signed [10:0] r_s6_rest0;
    logic [8:0]         r_s6_plen;
    logic [20:0]        n_s6_dby;
    logic [20:0]        n_s6_rest0;
    logic               n_s6_cent;
    logic               n_s6_quad;
    logic [8:0]         n_s6_plen;

    always_comb begin
        n_s6_dby   = 21'(r_s5_yr) * 21'd365 + 21'(r_s5_yr[YEAR_W-1:2])
                   - 21'(r_s5_q100) + 21'(r_s5_q100[5:2]);
        n_s6_rest0 = 21'(r_s5_n) - n_s6_dby;
        n_s6_cent  = (r_s5_yr == 12'(r_s5_q100) * 12'd100);
        n_s6_quad  = n_s6_cent && (r_s5_q100[1:0] == 2'b00);
        // dby(yr) - dby(yr-1)
        n_s6_plen  = 9'd365 + 9'(r_s5_yr[1:0] == 2'b00) - 9'(n_s6_cent) + 9'(n_s6_quad);
    end

    // ---------------- stage 7: step back a year when the estimate overshot ----------------
    logic              r_s7_ok;
    logic [YEAR_W-1:0] r_s7_yr;
    logic [REST_W-1:0] r_s7_rest;
    logic [10:0]       n_s7_sum;

    assign n_s7_sum = r_s6_rest0 + 11'(r_s6_plen);

    // ---------------- stage 8: March-based month ----------------
    logic              r_s8_ok;
    logic [YEAR_W-1:0] r_s8_yr;
    logic [REST_W-1:0] r_s8_rest;
    logic [MON_W-1:0]  r_s8_mi;

    // ---------------- stage 9: calendar fields, range check (output register) ----------------
    logic [DAY_W-1:0]  r_out_day;
    logic [MON_W-1:0]  r_out_month;
    logic [YEAR_W-1:0] r_out_year;
    logic [STAT_W-1:0] r_out_status;
    logic              n_s9_wrap;
    logic [YEAR_W-1:0] n_s9_ry;
    logic [MON_W-1:0]  n_s9_rm;
    logic [REST_W-1:0] n_s9_rd;

    always_comb begin
        n_s9_wrap = (r_s8_mi >= 4'd10);   // January, February: next calendar year
        n_s9_ry   = r_s8_yr + YEAR_W'(n_s9_wrap);
        n_s9_rm   = n_s9_wrap ? r_s8_mi - 4'd9 : r_s8_mi + 4'd3;
        n_s9_rd   = r_s8_rest - REST_W'(days_before_month(r_s8_mi)) + 10'd1;
    end

    // ---------------- data registers ----------------
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_chk <= chk;
            r_s0_off <= i_day_offset;
        end
        if (en[1]) begin
            r_s1_ok <= r_s0_chk.ok;
            r_s1_n  <= n_s1_n[DNUM_W-1:0];
        end
        if (en[2]) begin
            r_s2_ok <= r_s1_ok;
            r_s2_n  <= r_s1_n;
            r_s2_q0 <= n_s2_prod[43:32];
        end
        if (en[3]) begin
            r_s3_ok <= r_s2_ok;
            r_s3_n  <= r_s2_n;
            r_s3_q0 <= r_s2_q0;
            r_s3_x  <= 34'(r_s2_n) * 34'd10000 + 34'd14780;
            r_s3_t  <= 34'(r_s2_q0) * YR_DIV;
        end
        if (en[4]) begin
            r_s4_ok <= r_s3_ok;
            r_s4_n  <= r_s3_n;
            r_s4_yr <= r_s3_q0 + YEAR_W'(n_s4_rem >= YR_DIV);
        end
        if (en[5]) begin
            r_s5_ok   <= r_s4_ok;
            r_s5_n    <= r_s4_n;
            r_s5_yr   <= r_s4_yr;
            r_s5_q100 <= n_s5_prod[22:17];
        end
        if (en[6]) begin
            r_s6_ok    <= r_s5_ok;
            r_s6_yr    <= r_s5_yr;
            r_s6_rest0 <= n_s6_rest0[10:0];
            r_s6_plen  <= n_s6_plen;
        end
        if (en[7]) begin
            r_s7_ok <= r_s6_ok;
            if (r_s6_rest0 < 0) begin
                r_s7_yr   <= r_s6_yr - 12'd1;
                r_s7_rest <= n_s7_sum[REST_W-1:0];
            end else begin
                r_s7_yr   <= r_s6_yr;
                r_s7_rest <= r_s6_rest0[REST_W-1:0];
            end
        end
        if (en[8]) begin
            r_s8_ok   <= r_s7_ok;
            r_s8_yr   <= r_s7_yr;
            r_s8_rest <= r_s7_rest;
            r_s8_mi   <= month_index(r_s7_rest);
        end
        if (en[9]) begin
            if (!r_s8_ok) begin
                r_out_day    <= '0;
                r_out_month  <= '0;
                r_out_year   <= '0;
                r_out_status <= ST_BAD_IN;
            end else if ((n_s9_ry < YEAR_MIN) || (n_s9_ry > YEAR_MAX)) begin
                r_out_day    <= '0;
                r_out_month  <= '0;
                r_out_year   <= '0;
                r_out_status <= ST_RANGE;
            end else begin
                r_out_day    <= n_s9_rd[DAY_W-1:0];
                r_out_month  <= n_s9_rm;
                r_out_year   <= n_s9_ry;
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_out_day   = r_out_day;
    assign o_out_month = r_out_month;
    assign o_out_year  = r_out_year;
    assign o_status    = r_out_status;

    // ---------------- checks ----------------
    `DAD_ASSERT_IMP(a_stall_only_full, !o_in_ready, o_out_valid, "input stalled with output empty")
    `DAD_ASSERT_IMP(a_err_zero, o_out_valid && (o_status != ST_OK), (o_out_day == '0) && (o_out_month == '0) && (o_out_year == '0), "error beat carries a date")
    `DAD_ASSERT_IMP(a_ok_fields, o_out_valid && (o_status == ST_OK), (o_out_day != '0) && (o_out_month != '0) && (o_out_month <= 4'd12) && (o_out_year >= YEAR_MIN) && (o_out_year <= YEAR_MAX), "ok beat with bad date")
    `DAD_ASSERT_IMP(a_status_code, o_out_valid, (o_status == ST_OK) || (o_status == ST_BAD_IN) || (o_status == ST_RANGE), "unknown status")

endmodule

### design/dad_date_check.sv
module dad_date_check
    import dad_pkg::*;
(
    input  logic [DAY_W-1:0]  i_day,
    input  logic [MON_W-1:0]  i_month,
    input  logic [YEAR_W-1:0] i_year,
    output t_chk              o_chk
);

    logic [DAY_W-1:0]  mlen;
    logic [MON_W-1:0]  mm;
    logic [YEAR_W-1:0] yy;
    logic [21:0]       acc;

    always_comb begin
        case (i_month)
            4'd2:                      mlen = (i_year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   mlen = 5'd30;
            default:                   mlen = 5'd31;
        endcase
    end

    // Jan/Feb count as months 10/11 of the year before
    assign mm = (i_month >= 4'd3) ? i_month - 4'd3 : i_month + 4'd9;
    assign yy = i_year - ((i_month < 4'd3) ? 12'd1 : 12'd0);

    // 365*yy + yy/4 - yy/100 + yy/400 reduces to 365*yy + yy/4 - 15 over 1949..2049;
    // the -15 and the -1 on the day are applied in the next stage
    assign acc = 22'(yy) * 22'd365 + 22'(yy[YEAR_W-1:2])
               + 22'(days_before_month(mm)) + 22'(i_day);

    assign o_chk.ok = (i_day != '0) && (i_month != '0) && (i_month <= 4'd12)
                   && (i_year >= YEAR_MIN) && (i_year <= YEAR_MAX) && (i_day <= mlen);
    assign o_chk.days = acc[DNUM_W-1:0];

endmodule

### dv/dad_checker.sv
module dad_checker
    import dad_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [DAY_W-1:0]        i_in_day,
    input  logic [MON_W-1:0]        i_in_month,
    input  logic [YEAR_W-1:0]       i_in_year,
    input  logic signed [OFF_W-1:0] i_day_offset,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [DAY_W-1:0]        i_out_day,
    input  logic [MON_W-1:0]        i_out_month,
    input  logic [YEAR_W-1:0]       i_out_year,
    input  logic [STAT_W-1:0]       i_status,
    output int                      o_fail_cnt,
    output int                      o_dates_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [STAT_W-1:0] status;
    } t_date_res;

    t_date_res date_due_q[$];
    int        fail_cnt  = 0;
    int        due_cnt   = 0;

    assign o_fail_cnt  = fail_cnt;
    assign o_dates_due = due_cnt;

    // days from the epoch to 1 March of year y
    function automatic longint days_to_year(input longint y);
        return y * 365 + y / 4 - y / 100 + y / 400;
    endfunction

    function automatic t_date_res shift_date(input logic [DAY_W-1:0] d,
                                             input logic [MON_W-1:0] m,
                                             input logic [YEAR_W-1:0] y,
                                             input logic signed [OFF_W-1:0] off);
        t_date_res r;
        int        mlen;
        longint    mm, yy, n, yr, rest, mi, ry;
        r        = '0;
        r.status = ST_BAD_IN;
        if (d < 1 || d > 31 || m < 1 || m > 12 || y < YEAR_MIN || y > YEAR_MAX) begin
            return r;
        end
        if (m == 2) begin
            mlen = (y % 4 == 0) ? 29 : 28;
        end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
            mlen = 30;
        end else begin
            mlen = 31;
        end
        if (d > mlen) begin
            return r;
        end
        // March-based month; Jan/Feb count against the previous year
        mm   = (longint'(m) + 9) % 12;
        yy   = longint'(y) - mm / 10;
        n    = days_to_year(yy) + (mm * 306 + 5) / 10 + longint'(d) - 1 + longint'(off);
        yr   = (10000 * n + 14780) / 3652425;
        rest = n - days_to_year(yr);
        if (rest < 0) begin
            yr   = yr - 1;
            rest = n - days_to_year(yr);
        end
        mi = (52 + 100 * rest) / 3060;
        ry = yr + (mi + 2) / 12;
        if (ry < longint'(YEAR_MIN) || ry > longint'(YEAR_MAX)) begin
            r.status = ST_RANGE;
            return r;
        end
        r.day    = DAY_W'(rest - (mi * 306 + 5) / 10 + 1);
        r.month  = MON_W'((mi + 2) % 12 + 1);
        r.year   = YEAR_W'(ry);
        r.status = ST_OK;
        return r;
    endfunction

    task automatic flag_beat(input string what, input t_date_res want, input t_date_res got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: %s: exp d=%0d m=%0d y=%0d st=%0d, got d=%0d m=%0d y=%0d st=%0d",
                     $realtime, what, want.day, want.month, want.year, want.status,
                     got.day, got.month, got.year, got.status);
        end
    endtask

    always @(posedge i_clk) begin
        t_date_res got;
        t_date_res want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                date_due_q.push_back(shift_date(i_in_day, i_in_month, i_in_year,
                                                i_day_offset));
            end
            if (i_out_valid && i_out_ready) begin
                got = '{day: i_out_day, month: i_out_month, year: i_out_year,
                        status: i_status};
                if (date_due_q.size() == 0) begin
                    flag_beat("unexpected beat", '0, got);
                end else begin
                    want = date_due_q.pop_front();
                    if (got.day !== want.day || got.month !== want.month ||
                        got.year !== want.year || got.status !== want.status) begin
                        flag_beat("mismatch", want, got);
                    end
                end
            end
        end
        due_cnt <= date_due_q.size();
    end

endmodule

### dv/tb_top.sv
module tb_top
    import dad_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 400_000;   // cycles; slowest legal run is far below this

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic [DAY_W-1:0]        i_in_day     = '0;
    logic [MON_W-1:0]        i_in_month   = '0;
    logic [YEAR_W-1:0]       i_in_year    = '0;
    logic signed [OFF_W-1:0] i_day_offset = '0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic [DAY_W-1:0]        o_out_day;
    logic [MON_W-1:0]        o_out_month;
    logic [YEAR_W-1:0]       o_out_year;
    logic [STAT_W-1:0]       o_status;

    int   fail_cnt;
    int   dates_due;
    int   gap_pct   = 0;    // sender idle chance per cycle, in percent
    int   stall_pct = 0;    // receiver stall chance per cycle, in percent
    logic long_hold = 1'b0; // asks the receiver for one long hold-off

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    date_add_days dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_day     (i_in_day),
        .i_in_month   (i_in_month),
        .i_in_year    (i_in_year),
        .i_day_offset (i_day_offset),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_day    (o_out_day),
        .o_out_month  (o_out_month),
        .o_out_year   (o_out_year),
        .o_status     (o_status)
    );

    dad_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_day     (i_in_day),
        .i_in_month   (i_in_month),
        .i_in_year    (i_in_year),
        .i_day_offset (i_day_offset),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_day    (o_out_day),
        .i_out_month  (o_out_month),
        .i_out_year   (o_out_year),
        .i_status     (o_status),
        .o_fail_cnt   (fail_cnt),
        .o_dates_due  (dates_due)
    );

    // Receiver side. Random stalls per cycle, plus a single long hold-off on request
    // so the ten stages fill and o_in_ready drops while beats keep being offered.
    always @(posedge i_clk) begin
        int  hold_left;
        bit  hold_done;
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (long_hold && !hold_done) begin
            hold_left   = 80;
            hold_done   = 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offers one beat and holds it until taken, then maybe idles for a while.
    // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
    task automatic send_date(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                             input logic [YEAR_W-1:0] y, input int off);
        i_in_valid   <= 1'b1;
        i_in_day     <= d;
        i_in_month   <= m;
        i_in_year    <= y;
        i_day_offset <= OFF_W'(off);
        do @(posedge i_clk); while (!o_in_ready);
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    // Sender stops and waits for every outstanding result to come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (dates_due != 0);
    endtask

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int                phase_gap[4];
        int                phase_stall[4];
        int                pick;
        int                len;
        int                off;
        logic [DAY_W-1:0]  dy;
        logic [MON_W-1:0]  mo;
        logic [YEAR_W-1:0] yr;

        // no idling, sender idle, receiver stalling, both at a light rate
        phase_gap   = '{0, 83, 0, 24};
        phase_stall = '{0, 0, 83, 24};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed beats ---
        send_date(5'd1,  4'd1,  12'd1950, 0);          // first valid date
        send_date(5'd31, 4'd12, 12'd2049, 0);          // last valid date
        send_date(5'd1,  4'd1,  12'd1950, -1);         // result falls below the range
        send_date(5'd31, 4'd12, 12'd2049, 1);          // result falls above the range
        send_date(5'd29, 4'd2,  12'd2048, 0);          // leap day, leap year
        send_date(5'd29, 4'd2,  12'd2049, 0);          // leap day, common year
        send_date(5'd28, 4'd2,  12'd2049, 1);          // end of February rolls to March
        send_date(5'd29, 4'd2,  12'd2000, 365);
        send_date(5'd0,  4'd5,  12'd2000, 3);          // day zero
        send_date(5'd31, 4'd4,  12'd2000, 3);          // past the end of a 30-day month
        send_date(5'd31, 4'd15, 12'd2000, 3);          // month all ones
        send_date(5'd10, 4'd0,  12'd2000, 3);          // month zero
        send_date(5'd10, 4'd13, 12'd2000, 3);          // month just past December
        send_date(5'd15, 4'd6,  12'd1949, 0);          // start year below range
        send_date(5'd15, 4'd6,  12'd2050, 0);          // start year above range
        send_date(5'd31, 4'd1,  12'd4095, 0);          // year all ones
        send_date(5'd1,  4'd1,  12'd0,    0);          // year zero
        send_date(5'd15, 4'd6,  12'd2000, 131071);     // largest offset
        send_date(5'd15, 4'd6,  12'd2000, -131072);    // most negative offset
        send_date(5'd31, 4'd12, 12'd1999, 1);          // year rollover
        send_date(5'd1,  4'd3,  12'd2000, -1);         // back into a leap February
        send_date(5'd1,  4'd3,  12'd1990, -1);         // back into a common February
        send_date(5'd31, 4'd5,  12'd2049, 214);        // lands exactly on the last day
        send_date(5'd1,  4'd1,  12'd1950, 36524);      // spans the whole range
        send_date(5'd31, 4'd12, 12'd2049, -36524);

        // --- random beats, four idling phases ---
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            gap_pct   = phase_gap[ph];
            stall_pct <= phase_stall[ph];
            for (int k = 0; k < 500; k++) begin
                // long hold-off in the unthrottled phase: pipeline fills, input stalls
                if (ph == 0 && k == 200) begin
                    long_hold <= 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 75) begin
                    // well-formed date, with month ends favoured
                    yr  = YEAR_W'($urandom_range(2049, 1950));
                    mo  = MON_W'($urandom_range(12, 1));
                    len = (mo == 2) ? ((yr % 4 == 0) ? 29 : 28) :
                          (mo == 4 || mo == 6 || mo == 9 || mo == 11) ? 30 : 31;
                    dy  = ($urandom_range(99) < 30) ? DAY_W'(len - $urandom_range(1, 0))
                                                    : DAY_W'($urandom_range(len, 1));
                    pick = $urandom_range(99);
                    if (pick < 45) begin
                        off = int'($urandom_range(800)) - 400;
                    end else if (pick < 80) begin
                        off = int'($urandom_range(73200)) - 36600;
                    end else begin
                        off = int'($urandom_range(262143)) - 131072;
                    end
                end else if (pick < 87) begin
                    // nearly valid: day may overrun the month, year may sit just outside
                    dy  = DAY_W'($urandom_range(31));
                    mo  = MON_W'($urandom_range(12, 1));
                    yr  = YEAR_W'($urandom_range(2054, 1945));
                    off = int'($urandom_range(2000)) - 1000;
                end else begin
                    // raw noise over every bit of every field
                    dy  = DAY_W'($urandom);
                    mo  = MON_W'($urandom);
                    yr  = YEAR_W'($urandom);
                    off = int'($urandom_range(262143)) - 131072;
                end
                send_date(dy, mo, yr, off);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
